// ----- rtl/pbr_pkg.sv -----
// pbr_pkg: fixed-point constants and the stage-six bundle of the brdf term pipeline
// no dependencies; used by the datapath and the top level
package pbr_pkg;

  localparam int unsigned InW   = 17;
  localparam int unsigned QW    = 29;
  localparam int unsigned DNumW = 40;
  localparam int unsigned DDenW = 35;
  localparam int unsigned GNumW = 36;
  localparam int unsigned GDenW = 29;

  localparam logic [InW-1:0] InOne    = 17'd65536;
  localparam logic [InW-1:0] RoughMin = 17'd5571;
  localparam logic [QW-1:0]  QOne     = 29'h1000_0000;
  localparam logic [25:0]    PiQ24    = 26'd52707179;

  typedef struct packed {
    logic [7:0]       fresnel_byte;
    logic [DNumW-1:0] dist_num;
    logic [DDenW-1:0] dist_den;
    logic [GNumW-1:0] geom_num;
    logic [GDenW-1:0] geom_den;
  } pbr_terms_t;

endpackage

// ----- rtl/pbr_item_if.sv -----
// pbr_item_if: input channel of the brdf term evaluator, valid/ready plus two q1.16 fields
// no dependencies
interface pbr_item_if;
  logic        valid;
  logic        ready;
  logic [16:0] angle_cosine;
  logic [16:0] rough_or_reflect;

  modport source (output valid, output angle_cosine, output rough_or_reflect, input ready);
  modport sink (input valid, input angle_cosine, input rough_or_reflect, output ready);
endinterface

// ----- rtl/pbr_result_if.sv -----
// pbr_result_if: result channel of the brdf term evaluator, valid/ready plus three bytes
// no dependencies
interface pbr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] fresnel_byte;
  logic [7:0] distribution_byte;
  logic [7:0] geometry_byte;

  modport source (output valid, output fresnel_byte, output distribution_byte,
                  output geometry_byte, input ready);
  modport sink (input valid, input fresnel_byte, input distribution_byte,
                input geometry_byte, output ready);
endinterface

// ----- rtl/pbr_term_datapath.sv -----
// pbr_term_datapath: six multiply stages forming fresnel byte and both quotient operands
// depends on pbr_pkg
module pbr_term_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [16:0]            angle_cosine_i,
  input  logic [16:0]            rough_or_reflect_i,
  output logic                   valid_o,
  output pbr_pkg::pbr_terms_t    terms_o
);

  localparam int unsigned QW = pbr_pkg::QW;

  logic [5:0] valid_q;

  // stage 1
  logic [16:0]   c16_d, p16_d, r16_d;
  logic [QW-1:0] c_w, p_w, r_w;
  logic [57:0]   m_dd, m_rr, m_cc;
  logic [59:0]   m_gg;
  logic [29:0]   gp_w;
  logic [16:0]   c1_q, p1_q;
  logic [QW-1:0] d1_q, d2_q1, a1_q, n2_q1, k1_q;
  // stage 2
  logic [57:0]   m_d4, m_a2, m_gc;
  logic [QW-1:0] c1w, gden_d;
  logic [16:0]   p2_q;
  logic [QW-1:0] d2_q, d4_q, a2_q, n2_q2, gden_q2;
  logic [35:0]   gnum_q2;
  // stage 3
  logic [57:0]   m_d5, m_t;
  logic [16:0]   p3_q;
  logic [QW-1:0] d5_q, e_q, a2_q3, gden_q3;
  logic [35:0]   gnum_q3;
  // stage 4
  logic [57:0]   m_fm, m_ee;
  logic [QW-1:0] p3w;
  logic [16:0]   p4_q;
  logic [QW-1:0] fm_q;
  logic [36:0]   ees_q;
  logic [39:0]   dnum_q4;
  logic [QW-1:0] gden_q4;
  logic [35:0]   gnum_q4;
  // stage 5
  logic [QW:0]   f_w;
  logic [37:0]   m_f255;
  logic [8:0]    fb_w;
  logic [7:0]    fb_q5;
  logic [43:0]   lo_q;
  logic [44:0]   hi_q;
  logic [39:0]   dnum_q5;
  logic [QW-1:0] gden_q5;
  logic [35:0]   gnum_q5;
  // stage 6
  logic [62:0]   pi_sum;
  pbr_pkg::pbr_terms_t terms_q;

  always_comb begin
    c16_d = (angle_cosine_i > pbr_pkg::InOne) ? pbr_pkg::InOne : angle_cosine_i;
    p16_d = (rough_or_reflect_i > pbr_pkg::InOne) ? pbr_pkg::InOne : rough_or_reflect_i;
    r16_d = (p16_d < pbr_pkg::RoughMin) ? pbr_pkg::RoughMin : p16_d;
    c_w   = {c16_d, 12'b0};
    p_w   = {p16_d, 12'b0};
    r_w   = {r16_d, 12'b0};
    gp_w  = 30'(pbr_pkg::QOne) + 30'(p_w);
    m_dd  = 58'(pbr_pkg::QOne - c_w) * 58'(pbr_pkg::QOne - c_w);
    m_rr  = 58'(r_w) * 58'(r_w);
    m_cc  = 58'(c_w) * 58'(c_w);
    m_gg  = 60'(gp_w) * 60'(gp_w);

    c1w    = {c1_q, 12'b0};
    m_d4   = 58'(d2_q1) * 58'(d2_q1);
    m_a2   = 58'(a1_q) * 58'(a1_q);
    m_gc   = 58'(c1w) * 58'(pbr_pkg::QOne - k1_q);
    gden_d = m_gc[56:28] + k1_q;

    m_d5 = 58'(d4_q) * 58'(d2_q);
    m_t  = 58'(n2_q2) * 58'(pbr_pkg::QOne - a2_q);

    p3w  = {p3_q, 12'b0};
    m_fm = 58'(pbr_pkg::QOne - p3w) * 58'(d5_q);
    m_ee = 58'(e_q) * 58'(e_q);

    f_w    = 30'({p4_q, 12'b0}) + 30'(fm_q);
    m_f255 = (38'(f_w) << 8) - 38'(f_w);
    fb_w   = m_f255[36:28];

    pi_sum = (63'(hi_q) << 18) + 63'(lo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q    <= c16_d;
      p1_q    <= p16_d;
      d1_q    <= pbr_pkg::QOne - c_w;
      d2_q1   <= m_dd[56:28];
      a1_q    <= m_rr[56:28];
      n2_q1   <= m_cc[56:28];
      k1_q    <= m_gg[59:31];

      p2_q    <= p1_q;
      d2_q    <= d1_q;
      d4_q    <= m_d4[56:28];
      a2_q    <= m_a2[56:28];
      n2_q2   <= n2_q1;
      gden_q2 <= gden_d;
      gnum_q2 <= (36'(c1w) << 8) - 36'(c1w);

      p3_q    <= p2_q;
      d5_q    <= m_d5[56:28];
      e_q     <= pbr_pkg::QOne - m_t[56:28];
      a2_q3   <= a2_q;
      gden_q3 <= gden_q2;
      gnum_q3 <= gnum_q2;

      p4_q    <= p3_q;
      fm_q    <= m_fm[56:28];
      ees_q   <= m_ee[56:20];
      dnum_q4 <= (40'(a2_q3) << 12) - (40'(a2_q3) << 4);
      gden_q4 <= gden_q3;
      gnum_q4 <= gnum_q3;

      fb_q5   <= (fb_w > 9'd255) ? 8'hFF : fb_w[7:0];
      lo_q    <= 44'(ees_q[17:0]) * 44'(pbr_pkg::PiQ24);
      hi_q    <= 45'(ees_q[36:18]) * 45'(pbr_pkg::PiQ24);
      dnum_q5 <= dnum_q4;
      gden_q5 <= gden_q4;
      gnum_q5 <= gnum_q4;

      terms_q.fresnel_byte <= fb_q5;
      terms_q.dist_num     <= dnum_q5;
      terms_q.dist_den     <= pi_sum[62:28];
      terms_q.geom_num     <= gnum_q5;
      terms_q.geom_den     <= gden_q5;
    end
  end

  assign valid_o = valid_q[5];
  assign terms_o = terms_q;

endmodule

// ----- rtl/pbr_byte_div.sv -----
// pbr_byte_div: five-stage restoring divider giving a byte quotient that saturates at 255
// no dependencies; a zero divisor also saturates
module pbr_byte_div #(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 35
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [7:0]       quot_o
);

  localparam int unsigned CW = (NUM_W > DEN_W + 8) ? NUM_W : DEN_W + 8;

  logic [NUM_W-1:0] rem_q [5];
  logic [DEN_W-1:0] den_q [5];
  logic [7:0]       quo_q [5];
  logic             sat_q [5];
  logic [NUM_W-1:0] rem_d [5];
  logic [7:0]       quo_d [5];
  logic             sat_d;

  always_comb begin
    logic [CW-1:0] r;
    logic [CW-1:0] dsh;
    int            b;
    sat_d    = (den_i == '0) || (CW'(num_i) >= (CW'(den_i) << 8));
    rem_d[0] = num_i;
    quo_d[0] = '0;
    for (int s = 1; s < 5; s++) begin
      r  = CW'(rem_q[s-1]);
      quo_d[s] = quo_q[s-1];
      // two quotient bits per stage, msb first
      for (int j = 0; j < 2; j++) begin
        b   = 9 - 2 * s - j;
        dsh = CW'(den_q[s-1]) << b;
        if (r >= dsh) begin
          r           = r - dsh;
          quo_d[s][b] = 1'b1;
        end
      end
      rem_d[s] = r[NUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      den_q[0] <= den_i;
      quo_q[0] <= quo_d[0];
      sat_q[0] <= sat_d;
      for (int s = 1; s < 5; s++) begin
        rem_q[s] <= rem_d[s];
        den_q[s] <= den_q[s-1];
        quo_q[s] <= quo_d[s];
        sat_q[s] <= sat_q[s-1];
      end
    end
  end

  assign quot_o = sat_q[4] ? 8'hFF : quo_q[4];

endmodule

// ----- rtl/pbr_brdf_term_evaluator.sv -----
// pbr_brdf_term_evaluator: streaming fresnel, ggx distribution and geometry byte evaluator
// depends on pbr_pkg, pbr_item_if, pbr_result_if, pbr_term_datapath, pbr_byte_div
//
// usage
//   in_i carries one beat per texel: angle_cosine and rough_or_reflect, q1.16 with
//   65536 as one; larger codes are clamped to one. out_o returns one beat per input
//   beat, in order, with the three bytes.
//   an accepted input beat passes six multiply stages (the pi product split in two
//   halves) then five divider stages (range check, then two quotient bits per
//   stage) that run the distribution and geometry quotients side by side.
//   throughput is one beat per cycle while skid is empty; in_i.ready is registered.
//   a one-entry skid register after the last stage catches the result when the
//   receiver stalls; while it is full the pipeline holds and in_i.ready is low.
//   reset clears the valid bits and the skid entry; payload registers are not reset.
module pbr_brdf_term_evaluator (
  input  logic          clk_i,
  input  logic          rst_ni,
  pbr_item_if.sink      in_i,
  pbr_result_if.source  out_o
);

  logic                en;
  logic                dp_valid;
  pbr_pkg::pbr_terms_t terms;
  logic [7:0]          dist_byte, geom_byte;
  logic [4:0]          valid_q;
  logic [7:0]          fres_q [5];
  logic                skid_v_q;
  logic [7:0]          skid_f_q, skid_d_q, skid_g_q;
  logic                last_v;

  assign en      = !skid_v_q;
  assign in_i.ready = en;

  pbr_term_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (en),
    .valid_i            (in_i.valid),
    .angle_cosine_i     (in_i.angle_cosine),
    .rough_or_reflect_i (in_i.rough_or_reflect),
    .valid_o            (dp_valid),
    .terms_o            (terms)
  );

  pbr_byte_div #(.NUM_W(pbr_pkg::DNumW), .DEN_W(pbr_pkg::DDenW)) u_dist_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (terms.dist_num),
    .den_i  (terms.dist_den),
    .quot_o (dist_byte)
  );

  pbr_byte_div #(.NUM_W(pbr_pkg::GNumW), .DEN_W(pbr_pkg::GDenW)) u_geom_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (terms.geom_num),
    .den_i  (terms.geom_den),
    .quot_o (geom_byte)
  );

  assign last_v = valid_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        valid_q <= {valid_q[3:0], dp_valid};
      end
      if (skid_v_q) begin
        if (out_o.ready) skid_v_q <= 1'b0;
      end else if (last_v && !out_o.ready) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  // fresnel byte waits alongside the divider stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      fres_q[0] <= terms.fresnel_byte;
      for (int s = 1; s < 5; s++) fres_q[s] <= fres_q[s-1];
    end
    if (!skid_v_q && last_v && !out_o.ready) begin
      skid_f_q <= fres_q[4];
      skid_d_q <= dist_byte;
      skid_g_q <= geom_byte;
    end
  end

  assign out_o.valid             = skid_v_q || last_v;
  assign out_o.fresnel_byte      = skid_v_q ? skid_f_q : fres_q[4];
  assign out_o.distribution_byte = skid_v_q ? skid_d_q : dist_byte;
  assign out_o.geometry_byte     = skid_v_q ? skid_g_q : geom_byte;

endmodule

// ----- rtl/pbr_brdf_checker.sv -----
// pbr_brdf_checker: port-level assertions for the brdf term evaluator, with its bind
// depends on the top level pbr_brdf_term_evaluator
module pbr_brdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] fresnel_byte_i,
  input logic [7:0] distribution_byte_i,
  input logic [7:0] geometry_byte_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(fresnel_byte_i) && $stable(distribution_byte_i)
      && $stable(geometry_byte_i))
    else $error("result payload changed while stalled");

  // input side only blocks while a result is pending
  a_busy_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input blocked with no result pending");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i && out_ready_i |=> in_ready_i)
    else $error("input not released after skid drained");

endmodule

bind pbr_brdf_term_evaluator pbr_brdf_checker u_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .fresnel_byte_i      (out_o.fresnel_byte),
  .distribution_byte_i (out_o.distribution_byte),
  .geometry_byte_i     (out_o.geometry_byte)
);
